>>> rtl/core/ptrm_pkg.sv
// ----------------------------------------------------------------------------
// ptrm_pkg: shared types and constants of the task release monitor.
// Result kinds, action codes, run states and the sequencer state type.
// ----------------------------------------------------------------------------
package ptrm_pkg;

  // Input action codes.
  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_SETPER = 3'd1;
  localparam logic [2:0] ACT_SETSPO = 3'd2;
  localparam logic [2:0] ACT_FINISH = 3'd3;
  localparam logic [2:0] ACT_WAIT   = 3'd4;
  localparam logic [2:0] ACT_STATS  = 3'd5;

  // Result kinds.
  localparam logic [2:0] K_RELEASE = 3'd0;
  localparam logic [2:0] K_MISS    = 3'd1;
  localparam logic [2:0] K_TICK    = 3'd2;
  localparam logic [2:0] K_STATS   = 3'd3;
  localparam logic [2:0] K_ACK     = 3'd4;
  localparam logic [2:0] K_ERROR   = 3'd5;

  // Run states of an entry.
  localparam logic [1:0] RS_STARTED = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_BLOCKED = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_EVAL = 6'b000100,
    ST_PRED = 6'b001000,
    ST_OUT  = 6'b010000,
    ST_NEXT = 6'b100000
  } state_e;

endpackage

>>> rtl/core/ptrm_alu.sv
// ----------------------------------------------------------------------------
// ptrm_alu: shared time adder and comparator.
// Computes a + b both wrapped and saturated, and compares against a time.
// ----------------------------------------------------------------------------
module ptrm_alu #(
  parameter int TimeBits = 32
) (
  input  logic [TimeBits-1:0] a_i,
  input  logic [TimeBits-1:0] b_i,
  input  logic [TimeBits-1:0] t_i,
  output logic [TimeBits-1:0] wrap_o,
  output logic                t_ge_a_o,
  output logic                t_le_sat_o,
  output logic                sat_lt_t_o
);
  logic [TimeBits:0] sum;
  logic [TimeBits-1:0] sat;

  // One wide add shared by the saturated checks and the wrapped output.
  assign sum    = {1'b0, a_i} + {1'b0, b_i};
  assign wrap_o = sum[TimeBits-1:0];
  assign sat    = sum[TimeBits] ? {TimeBits{1'b1}} : sum[TimeBits-1:0];
  assign t_ge_a_o   = t_i >= a_i;
  assign t_le_sat_o = t_i <= sat;
  assign sat_lt_t_o = sat < t_i;
endmodule

>>> rtl/core/periodic_task_release_monitor_unit.sv
// ----------------------------------------------------------------------------
// periodic_task_release_monitor_unit: periodic/sporadic task release table.
// ----------------------------------------------------------------------------
// A tick walks the entries one per pass of a small sequencer through a shared
// adder/comparator. Each valid entry passes through five states (read,
// evaluate, decide, output, advance), and an invalid one is skipped in the read
// state, which also emits the tick done result once the walk is over. Every
// other action passes through the read and evaluate states. Any result that
// waits on out_stall_i holds the sequencer for as long as the stall lasts.
// The block takes one item at a time; in_stall_o is high while an item is
// in work.
module periodic_task_release_monitor_unit #(
  parameter int TASKS     = 8,
  parameter int TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [2:0]  task_index_i,
  input  logic [31:0] phase_i,
  input  logic [31:0] period_i,
  input  logic [31:0] deadline_i,
  input  logic [2:0]  predecessor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [2:0]  task_index_res_o,
  output logic [31:0] activations_o,
  output logic [31:0] misses_o,
  output logic [31:0] tick_now_o,
  output logic        last_o
);
  import ptrm_pkg::*;

  localparam int IW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);

  // Entry storage.
  logic [TASKS-1:0]     valid_q;
  logic                 spor_q [TASKS];
  logic [2:0]           pred_q [TASKS];
  logic [TIME_BITS-1:0] per_q  [TASKS];
  logic [TIME_BITS-1:0] dl_q   [TASKS];
  logic [TIME_BITS-1:0] nrel_q [TASKS];
  logic [TIME_BITS-1:0] cact_q [TASKS];
  logic [31:0]          acnt_q [TASKS];
  logic [31:0]          mcnt_q [TASKS];
  logic [1:0]           rs_q   [TASKS];
  logic [TIME_BITS-1:0] fin_q  [TASKS];

  logic [3:0]           max_q;
  logic [TIME_BITS-1:0] tick_q;
  state_e               st_q;
  logic [2:0]           act_q, idx_q, ipred_q;
  logic [31:0]          iph_q, iper_q, idl_q;
  logic [CW-1:0]        walk_q;
  logic [IW-1:0]        wi;
  logic                 pend_q;   // a pending walk result waits in ST_OUT

  // Working registers loaded from the addressed entry.
  logic                 e_spor_q;
  logic [2:0]           e_pred_q;
  logic [TIME_BITS-1:0] e_per_q, e_dl_q, e_nrel_q, e_cact_q;
  logic                 p_ok_q;
  logic                 win_ok_q; // tick lies inside the deadline window

  logic [TIME_BITS-1:0] alu_a, alu_b, alu_wrap;
  logic                 t_ge_a, t_le_sat, sat_lt_t;

  logic                 out_fire, out_free, out_load, idx_ok, is_tick;
  logic                 set_ok, entry_ok, walk_done;
  logic [IW-1:0]        ai;
  logic [2:0]           eval_kind, rel_kind;
  logic                 rel_pend;

  assign out_fire    = out_valid_o && !out_stall_i;
  assign out_free    = !out_valid_o || out_fire;
  assign in_stall_o  = (st_q != ST_IDLE);
  assign cfg_ready_o = (st_q == ST_IDLE);
  assign wi          = walk_q[IW-1:0];
  assign ai          = IW'(idx_q);
  assign idx_ok      = ({1'b0, idx_q} < 4'(TASKS)) || (TASKS >= 8);
  assign is_tick     = (act_q == ACT_TICK);
  assign set_ok      = idx_ok && ({1'b0, idx_q} < max_q);
  assign entry_ok    = idx_ok && valid_q[ai];
  assign walk_done   = (walk_q == CW'(TASKS));

  // A new result enters the output register in these cases only.
  assign out_load = out_free && ((st_q == ST_RD && is_tick && walk_done) ||
                                 (st_q == ST_EVAL && !is_tick) ||
                                 (st_q == ST_OUT && pend_q));

  // Shared arithmetic unit: next release plus deadline or period on a tick, current activation plus deadline otherwise.
  ptrm_alu #(.TimeBits(TIME_BITS)) u_alu (
    .a_i       (alu_a),
    .b_i       (alu_b),
    .t_i       (tick_q),
    .wrap_o    (alu_wrap),
    .t_ge_a_o  (t_ge_a),
    .t_le_sat_o(t_le_sat),
    .sat_lt_t_o(sat_lt_t)
  );

  always_comb begin
    alu_a = e_nrel_q;
    alu_b = e_dl_q;
    if (!is_tick) begin
      alu_a = e_cact_q;
    end else if (st_q == ST_PRED) begin
      alu_b = e_per_q;
    end
  end

  // Result kind of a single-result action.
  always_comb begin
    eval_kind = K_ERROR;
    case (act_q)
      ACT_SETPER, ACT_SETSPO: begin
        if (set_ok) begin
          eval_kind = K_ACK;
        end
      end
      ACT_FINISH, ACT_WAIT: begin
        if (entry_ok) begin
          eval_kind = K_ACK;
        end
      end
      ACT_STATS: begin
        if (entry_ok) begin
          eval_kind = K_STATS;
        end
      end
      default: eval_kind = K_ERROR;
    endcase
  end

  // Outcome of the walked entry.
  always_comb begin
    if (!e_spor_q) begin
      rel_pend = t_ge_a;
      rel_kind = win_ok_q ? K_RELEASE : K_MISS;
    end else begin
      rel_pend = p_ok_q;
      rel_kind = K_RELEASE;
    end
  end

  // Sequencer and storage updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      valid_q     <= '0;
      max_q       <= 4'd8;
      tick_q      <= '0;
      out_valid_o <= 1'b0;
      walk_q      <= '0;
      pend_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_fire) begin
        out_valid_o <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            act_q   <= action_i;
            idx_q   <= task_index_i;
            ipred_q <= predecessor_i;
            iph_q   <= phase_i;
            iper_q  <= period_i;
            idl_q   <= deadline_i;
            walk_q  <= '0;
            st_q    <= ST_RD;
          end
        end
        ST_RD: begin
          if (is_tick) begin
            if (walk_done) begin
              // Walk done: increment tick, emit tick done.
              if (out_free) begin
                tick_q <= tick_q + 1'b1;
                kind_o <= K_TICK; task_index_res_o <= '0;
                activations_o <= '0; misses_o <= '0;
                tick_now_o <= 32'(tick_q + 1'b1); last_o <= 1'b1;
                st_q <= ST_IDLE;
              end
            end else if (!valid_q[wi]) begin
              walk_q <= walk_q + 1'b1;
            end else begin
              e_spor_q <= spor_q[wi]; e_pred_q <= pred_q[wi];
              e_per_q  <= per_q[wi];  e_dl_q   <= dl_q[wi];
              e_nrel_q <= nrel_q[wi]; e_cact_q <= cact_q[wi];
              st_q <= ST_EVAL;
            end
          end else begin
            e_dl_q   <= dl_q[ai];
            e_cact_q <= cact_q[ai];
            st_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (is_tick) begin
            // Predecessor check for sporadic entries, window check for periodic.
            p_ok_q <= ({1'b0, e_pred_q} < 4'(TASKS) || TASKS >= 8) &&
                      valid_q[IW'(e_pred_q)] &&
                      rs_q[IW'(e_pred_q)] == RS_BLOCKED &&
                      fin_q[IW'(e_pred_q)] >= e_cact_q;
            win_ok_q <= t_le_sat;
            st_q <= ST_PRED;
          end else if (out_free) begin
            kind_o <= eval_kind; task_index_res_o <= idx_q;
            activations_o <= (eval_kind == K_STATS) ? acnt_q[ai] : '0;
            misses_o <= (eval_kind == K_STATS) ? mcnt_q[ai] : '0;
            tick_now_o <= 32'(tick_q); last_o <= 1'b1;
            st_q <= ST_IDLE;
            case (act_q)
              ACT_SETPER, ACT_SETSPO: begin
                if (set_ok) begin
                  valid_q[ai] <= 1'b1;
                  spor_q[ai]  <= (act_q == ACT_SETSPO);
                  pred_q[ai]  <= (act_q == ACT_SETSPO) ? ipred_q : 3'd0;
                  dl_q[ai]    <= TIME_BITS'(idl_q);
                  per_q[ai]   <= (act_q == ACT_SETPER) ? TIME_BITS'(iper_q) : '0;
                  nrel_q[ai]  <= (act_q == ACT_SETPER) ? TIME_BITS'(iph_q) : '0;
                  cact_q[ai]  <= (act_q == ACT_SETPER) ? TIME_BITS'(iph_q) : '0;
                  acnt_q[ai]  <= '0;
                  mcnt_q[ai]  <= '0;
                  rs_q[ai]    <= RS_STARTED;
                  fin_q[ai]   <= '0;
                end
              end
              ACT_FINISH: begin
                if (entry_ok) begin
                  rs_q[ai]  <= RS_BLOCKED;
                  fin_q[ai] <= tick_q;
                end
              end
              ACT_WAIT: begin
                if (entry_ok && sat_lt_t) begin
                  mcnt_q[ai] <= mcnt_q[ai] + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PRED: begin
          // Decide the entry's fate and stage its result once the output is free.
          if (out_free) begin
            pend_q <= rel_pend;
            kind_o <= rel_kind; task_index_res_o <= 3'(wi);
            activations_o <= '0; misses_o <= '0;
            tick_now_o <= 32'(tick_q); last_o <= 1'b0;
            if (!e_spor_q) begin
              if (t_ge_a) begin
                nrel_q[wi] <= alu_wrap;
                if (win_ok_q) begin
                  cact_q[wi] <= e_nrel_q;
                  acnt_q[wi] <= acnt_q[wi] + 1'b1;
                  rs_q[wi]   <= RS_RUNNING;
                end else begin
                  mcnt_q[wi] <= mcnt_q[wi] + 1'b1;
                  cact_q[wi] <= alu_wrap;
                end
              end
            end else if (p_ok_q) begin
              cact_q[wi] <= tick_q;
              acnt_q[wi] <= acnt_q[wi] + 1'b1;
              rs_q[wi]   <= RS_RUNNING;
            end
            st_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!pend_q || out_free) begin
            st_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          walk_q <= walk_q + 1'b1;
          st_q <= ST_RD;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule
